@@ src/variable_length_packet_fifo_assert.svh @@
// Assertion macros shared by the packet FIFO checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef VARIABLE_LENGTH_PACKET_FIFO_ASSERT_SVH
`define VARIABLE_LENGTH_PACKET_FIFO_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define VLPF_ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("packet fifo property violated");

// Plain condition that must hold at every clock edge outside reset.
`define VLPF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("packet fifo invariant violated");

`endif

@@ src/vlpf_pkg.sv @@
// Shared types and codes for the variable length packet FIFO.
// No dependencies; imported by the core, response stage and checker.
`default_nettype none

package vlpf_pkg;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      logic       rd_ok;
      logic       rd_last;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

@@ src/vlpf_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module vlpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/vlpf_core.sv @@
// Pointer and count logic of the packet FIFO: decides each transfer combinationally
// and drives the byte RAM and end-position RAM. Depends on vlpf_pkg.
`default_nettype none

module vlpf_core #(
   parameter int DATA_DEPTH = 4096,
   parameter int PKT_DEPTH  = 64,
   localparam int PW = $clog2(DATA_DEPTH),
   localparam int CW = $clog2(DATA_DEPTH + 1),
   localparam int EW = $clog2(PKT_DEPTH),
   localparam int KW = $clog2(PKT_DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 req_type,
   input  wire logic [7:0]           req_wr_byte,
   input  wire logic                 req_wr_last,
   output logic                      data_we,
   output logic      [PW-1:0]        data_waddr,
   output logic      [7:0]           data_wdata,
   output logic      [PW-1:0]        data_raddr,
   output logic                      end_we,
   output logic      [EW-1:0]        end_waddr,
   output logic      [PW-1:0]        end_wdata,
   output logic      [EW-1:0]        end_raddr,
   input  wire logic [PW-1:0]        end_rdata,
   output vlpf_pkg::result_type      result,
   output logic      [CW-1:0]        fill_bytes,
   output logic      [KW-1:0]        packet_count
);

   import vlpf_pkg::*;

   localparam logic [PW-1:0] POS_LAST   = PW'(DATA_DEPTH - 1);
   localparam logic [EW-1:0] IDX_LAST   = EW'(PKT_DEPTH - 1);
   localparam logic [CW:0]   DATA_LIMIT = (CW+1)'(DATA_DEPTH);
   localparam logic [KW-1:0] PKT_LIMIT  = KW'(PKT_DEPTH);

   logic [PW-1:0] read_pos_ff,       read_pos_in;
   logic [PW-1:0] commit_tail_ff,    commit_tail_in;
   logic [PW-1:0] write_pos_ff,      write_pos_in;
   logic [CW-1:0] stored_bytes_ff,   stored_bytes_in;
   logic [CW-1:0] pending_bytes_ff,  pending_bytes_in;
   logic          overflow_ff,       overflow_in;
   logic [EW-1:0] end_head_ff,       end_head_in;
   logic [EW-1:0] end_tail_ff,       end_tail_in;
   logic [KW-1:0] stored_packets_ff, stored_packets_in;
   // forwards an end position written to the entry the head is about to read
   logic          byp_valid_ff,      byp_valid_in;
   logic [PW-1:0] byp_data_ff,       byp_data_in;

   logic          room;
   logic [PW-1:0] write_pos_inc;
   logic [PW-1:0] read_pos_inc;
   logic [PW-1:0] wr_pos_after;
   logic [CW-1:0] pend_after;
   logic          ovf_after;
   logic [PW-1:0] head_end;

   assign room          = !overflow_ff &&
                          (({1'b0, stored_bytes_ff} + {1'b0, pending_bytes_ff}) < DATA_LIMIT);
   assign write_pos_inc = (write_pos_ff == POS_LAST) ? '0 : write_pos_ff + 1'b1;
   assign read_pos_inc  = (read_pos_ff == POS_LAST) ? '0 : read_pos_ff + 1'b1;
   assign wr_pos_after  = room ? write_pos_inc : write_pos_ff;
   assign pend_after    = room ? pending_bytes_ff + 1'b1 : pending_bytes_ff;
   assign ovf_after     = overflow_ff | !room;
   assign head_end      = byp_valid_ff ? byp_data_ff : end_rdata;

   always_comb begin
      read_pos_in       = read_pos_ff;
      commit_tail_in    = commit_tail_ff;
      write_pos_in      = write_pos_ff;
      stored_bytes_in   = stored_bytes_ff;
      pending_bytes_in  = pending_bytes_ff;
      overflow_in       = overflow_ff;
      end_head_in       = end_head_ff;
      end_tail_in       = end_tail_ff;
      stored_packets_in = stored_packets_ff;
      data_we           = 1'b0;
      end_we            = 1'b0;
      result.rd_ok      = 1'b0;
      result.rd_last    = 1'b0;
      result.status     = STATUS_OK;
      if (accept) begin
         if (req_type == REQ_WRITE) begin
            data_we = room;
            if (req_wr_last) begin
               if (ovf_after || stored_packets_ff >= PKT_LIMIT) begin
                  write_pos_in  = commit_tail_ff;
                  result.status = STATUS_REJECT;
               end else begin
                  end_we            = 1'b1;
                  end_tail_in       = (end_tail_ff == IDX_LAST) ? '0 : end_tail_ff + 1'b1;
                  stored_packets_in = stored_packets_ff + 1'b1;
                  stored_bytes_in   = stored_bytes_ff + pend_after;
                  commit_tail_in    = wr_pos_after;
                  write_pos_in      = wr_pos_after;
               end
               pending_bytes_in = '0;
               overflow_in      = 1'b0;
            end else begin
               write_pos_in     = wr_pos_after;
               pending_bytes_in = pend_after;
               overflow_in      = ovf_after;
            end
         end else begin
            if (stored_packets_ff == '0) begin
               result.status = STATUS_EMPTY;
            end else begin
               result.rd_ok = 1'b1;
               read_pos_in  = read_pos_inc;
               if (stored_bytes_ff != '0) begin
                  stored_bytes_in = stored_bytes_ff - 1'b1;
               end
               if (read_pos_inc == head_end) begin
                  result.rd_last    = 1'b1;
                  end_head_in       = (end_head_ff == IDX_LAST) ? '0 : end_head_ff + 1'b1;
                  stored_packets_in = stored_packets_ff - 1'b1;
               end
            end
         end
      end
   end

   assign byp_valid_in = end_we && (end_tail_ff == end_head_in);
   assign byp_data_in  = wr_pos_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pos_ff       <= '0;
         commit_tail_ff    <= '0;
         write_pos_ff      <= '0;
         stored_bytes_ff   <= '0;
         pending_bytes_ff  <= '0;
         overflow_ff       <= 1'b0;
         end_head_ff       <= '0;
         end_tail_ff       <= '0;
         stored_packets_ff <= '0;
         byp_valid_ff      <= 1'b0;
      end else begin
         read_pos_ff       <= read_pos_in;
         commit_tail_ff    <= commit_tail_in;
         write_pos_ff      <= write_pos_in;
         stored_bytes_ff   <= stored_bytes_in;
         pending_bytes_ff  <= pending_bytes_in;
         overflow_ff       <= overflow_in;
         end_head_ff       <= end_head_in;
         end_tail_ff       <= end_tail_in;
         stored_packets_ff <= stored_packets_in;
         byp_valid_ff      <= byp_valid_in;
      end
      byp_data_ff <= byp_data_in;
   end

   assign data_waddr   = write_pos_ff;
   assign data_wdata   = req_wr_byte;
   assign data_raddr   = read_pos_ff;
   assign end_waddr    = end_tail_ff;
   assign end_wdata    = wr_pos_after;
   // prefetch the end position of whichever packet will be at the head next cycle
   assign end_raddr    = end_head_in;
   assign fill_bytes   = stored_bytes_ff;
   assign packet_count = stored_packets_ff;

endmodule

`default_nettype wire

@@ src/vlpf_rsp.sv @@
// Result register of the packet FIFO: holds the strobe and decision of each
// transfer and merges in the byte RAM read data. Depends on vlpf_pkg.
`default_nettype none

module vlpf_rsp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire vlpf_pkg::result_type result,
   input  wire logic [7:0]           data_rdata,
   output logic                      rsp_valid,
   output logic      [7:0]           rsp_rd_byte,
   output logic                      rsp_rd_last,
   output logic      [1:0]           rsp_status
);

   import vlpf_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      result_ff <= result;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_rd_byte = result_ff.rd_ok ? data_rdata : 8'h00;
   assign rsp_rd_last = result_ff.rd_last;
   assign rsp_status  = result_ff.status;

endmodule

`default_nettype wire

@@ src/variable_length_packet_fifo.sv @@
// Store-and-forward FIFO of variable-length packets.
// Channels: a request is transferred at a rising edge with start high and busy low.
// req_type selects a write of one packet byte (req_wr_byte, req_wr_last) or a read
// of the next byte of the oldest stored packet. Every request gives exactly one
// response, shown for one cycle with rsp_valid high: read byte, last flag, status
// (ok, read while empty, packet rejected) and the committed byte and packet counts.
// The response follows in the next cycle; one request per cycle is taken,
// and busy stays low. Each request makes one access to the byte RAM and the
// end-position RAM, and the end position of the next head packet is prefetched,
// so nothing in the path iterates.
// A packet becomes readable only after its last byte commits; if any byte found
// no room or the packet count is at PKT_DEPTH, the whole packet is dropped.
// Reset empties the FIFO: the RAMs are not cleared, as reads only
// reach committed entries. The receiver cannot stall; responses are never held.
// Depends on vlpf_pkg, vlpf_ram, vlpf_core and vlpf_rsp.
`default_nettype none

module variable_length_packet_fifo #(
   parameter int DATA_DEPTH = 4096,
   parameter int PKT_DEPTH  = 64,
   localparam int PW = $clog2(DATA_DEPTH),
   localparam int CW = $clog2(DATA_DEPTH + 1),
   localparam int EW = $clog2(PKT_DEPTH),
   localparam int KW = $clog2(PKT_DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic          req_type,
   input  wire logic [7:0]    req_wr_byte,
   input  wire logic          req_wr_last,
   output logic               rsp_valid,
   output logic      [7:0]    rsp_rd_byte,
   output logic               rsp_rd_last,
   output logic      [1:0]    rsp_status,
   output logic      [CW-1:0] rsp_fill_bytes,
   output logic      [KW-1:0] rsp_packet_count
);

   import vlpf_pkg::*;

   logic          accept;
   result_type    result;
   logic          data_we;
   logic [PW-1:0] data_waddr;
   logic [7:0]    data_wdata;
   logic [PW-1:0] data_raddr;
   logic [7:0]    data_rdata;
   logic          end_we;
   logic [EW-1:0] end_waddr;
   logic [PW-1:0] end_wdata;
   logic [EW-1:0] end_raddr;
   logic [PW-1:0] end_rdata;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   vlpf_core #(
      .DATA_DEPTH (DATA_DEPTH),
      .PKT_DEPTH  (PKT_DEPTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .req_wr_byte  (req_wr_byte),
      .req_wr_last  (req_wr_last),
      .data_we      (data_we),
      .data_waddr   (data_waddr),
      .data_wdata   (data_wdata),
      .data_raddr   (data_raddr),
      .end_we       (end_we),
      .end_waddr    (end_waddr),
      .end_wdata    (end_wdata),
      .end_raddr    (end_raddr),
      .end_rdata    (end_rdata),
      .result       (result),
      .fill_bytes   (rsp_fill_bytes),
      .packet_count (rsp_packet_count)
   );

   vlpf_ram #(
      .WIDTH (8),
      .DEPTH (DATA_DEPTH)
   ) u_byte_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (data_waddr),
      .wdata (data_wdata),
      .raddr (data_raddr),
      .rdata (data_rdata)
   );

   vlpf_ram #(
      .WIDTH (PW),
      .DEPTH (PKT_DEPTH)
   ) u_end_ram (
      .clock (clock),
      .we    (end_we),
      .waddr (end_waddr),
      .wdata (end_wdata),
      .raddr (end_raddr),
      .rdata (end_rdata)
   );

   vlpf_rsp u_rsp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .result      (result),
      .data_rdata  (data_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_rd_byte (rsp_rd_byte),
      .rsp_rd_last (rsp_rd_last),
      .rsp_status  (rsp_status)
   );

endmodule

`default_nettype wire

@@ src/vlpf_checker.sv @@
// Port-level checker for the packet FIFO, bound to the top level.
// Depends on vlpf_pkg and variable_length_packet_fifo_assert.svh.
`default_nettype none

`include "variable_length_packet_fifo_assert.svh"

module vlpf_checker #(
   parameter int DATA_DEPTH = 4096,
   parameter int PKT_DEPTH  = 64,
   localparam int CW = $clog2(DATA_DEPTH + 1),
   localparam int KW = $clog2(PKT_DEPTH + 1)
) (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          start,
   input wire logic          busy,
   input wire logic          req_type,
   input wire logic          req_wr_last,
   input wire logic          rsp_valid,
   input wire logic          rsp_rd_last,
   input wire logic [1:0]    rsp_status,
   input wire logic [CW-1:0] rsp_fill_bytes,
   input wire logic [KW-1:0] rsp_packet_count
);

   import vlpf_pkg::*;

   // one response per request transfer, in the next cycle
   `VLPF_ASSERT_PROP(a_one_rsp, clock, reset, 1'b1 |=> (rsp_valid == $past(start && !busy)))
   `VLPF_ASSERT_ALWAYS(a_fill_bound, clock, reset, rsp_fill_bytes <= DATA_DEPTH)
   `VLPF_ASSERT_ALWAYS(a_pkt_bound, clock, reset, rsp_packet_count <= PKT_DEPTH)
   `VLPF_ASSERT_PROP(a_empty_rd, clock, reset, (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_packet_count == '0 && !rsp_rd_last))
   `VLPF_ASSERT_PROP(a_reject_src, clock, reset, (rsp_valid && rsp_status == STATUS_REJECT) |-> $past(req_type == REQ_WRITE && req_wr_last))

endmodule

bind variable_length_packet_fifo vlpf_checker #(
   .DATA_DEPTH (DATA_DEPTH),
   .PKT_DEPTH  (PKT_DEPTH)
) u_vlpf_checker (.*);

`default_nettype wire

@@ tb/variable_length_packet_fifo_tb.sv @@
// Self-checking bench for the variable length packet FIFO: directed and random byte traffic.
// A predictor inside the bench tracks the byte ring and packet end ring and checks every response.
// Depends on vlpf_pkg and variable_length_packet_fifo.
`default_nettype none

module variable_length_packet_fifo_tb;
   import vlpf_pkg::*;

   localparam int DATA_DEPTH = 4096;
   localparam int PKT_DEPTH  = 64;

   typedef struct {
      logic [7:0]  rd_byte;
      logic        rd_last;
      status_type  status;
      logic [12:0] fill_bytes;
      logic [6:0]  packet_count;
   } fifo_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = REQ_WRITE;
   logic [7:0]  req_wr_byte = 8'd0;
   logic        req_wr_last = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_rd_byte;
   logic        rsp_rd_last;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_fill_bytes;
   logic [6:0]  rsp_packet_count;

   variable_length_packet_fifo #(
      .DATA_DEPTH(DATA_DEPTH),
      .PKT_DEPTH (PKT_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_wr_byte     (req_wr_byte),
      .req_wr_last     (req_wr_last),
      .rsp_valid       (rsp_valid),
      .rsp_rd_byte     (rsp_rd_byte),
      .rsp_rd_last     (rsp_rd_last),
      .rsp_status      (rsp_status),
      .rsp_fill_bytes  (rsp_fill_bytes),
      .rsp_packet_count(rsp_packet_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Shadow copy of the FIFO contents and pointers
   logic [7:0]  shadow_bytes [DATA_DEPTH];
   logic [11:0] shadow_ends [PKT_DEPTH];
   logic [11:0] head_pos = '0;
   logic [11:0] commit_pos = '0;
   logic [11:0] tail_pos = '0;
   int          committed_bytes = 0;
   int          open_bytes = 0;
   bit          open_overflow = 1'b0;
   logic [5:0]  end_rd_idx = '0;
   logic [5:0]  end_wr_idx = '0;
   int          committed_pkts = 0;

   fifo_rsp_type predicted_rsp_q [$];
   int           mismatch_count = 0;
   int           idle_pct = 13;

   function automatic fifo_rsp_type apply_request(req_code_type op, logic [7:0] data, logic last);
      fifo_rsp_type r;
      r.rd_byte = 8'd0;
      r.rd_last = 1'b0;
      r.status  = STATUS_OK;
      if (op == REQ_WRITE) begin
         if (!open_overflow && committed_bytes + open_bytes < DATA_DEPTH) begin
            shadow_bytes[tail_pos] = data;
            tail_pos = tail_pos + 12'd1;
            open_bytes++;
         end else begin
            open_overflow = 1'b1;
         end
         if (last) begin
            if (open_overflow || committed_pkts >= PKT_DEPTH) begin
               tail_pos = commit_pos;   // drop the whole packet
               r.status = STATUS_REJECT;
            end else begin
               shadow_ends[end_wr_idx] = tail_pos;
               end_wr_idx = end_wr_idx + 6'd1;
               committed_pkts++;
               committed_bytes += open_bytes;
               commit_pos = tail_pos;
            end
            open_bytes = 0;
            open_overflow = 1'b0;
         end
      end else if (committed_pkts == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.rd_byte = shadow_bytes[head_pos];
         head_pos = head_pos + 12'd1;
         if (committed_bytes > 0) committed_bytes--;
         if (head_pos == shadow_ends[end_rd_idx]) begin
            r.rd_last = 1'b1;
            end_rd_idx = end_rd_idx + 6'd1;
            committed_pkts--;
         end
      end
      r.fill_bytes   = 13'(committed_bytes);
      r.packet_count = 7'(committed_pkts);
      return r;
   endfunction

   // One transfer on the request channel; the response is predicted at acceptance
   task automatic send_item(req_code_type op, logic [7:0] data, logic last);
      start       <= 1'b1;
      req_type    <= op;
      req_wr_byte <= data;
      req_wr_last <= last;
      do @(posedge clock); while (busy);
      predicted_rsp_q.push_back(apply_request(op, data, last));
      // each cycle after a transfer idles with probability idle_pct
      while ($urandom_range(99) < idle_pct) begin
         start       <= 1'b0;
         req_type    <= req_code_type'($urandom_range(1));
         req_wr_byte <= 8'($urandom);
         req_wr_last <= 1'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_packet(int len, logic [7:0] seed);
      for (int i = 0; i < len; i++)
         send_item(REQ_WRITE, seed + 8'(i), i == len - 1);
   endtask

   task automatic send_reads(int n);
      repeat (n) send_item(REQ_READ, 8'($urandom), 1'($urandom));
   endtask

   task automatic drain_fifo();
      while (committed_pkts != 0) send_reads(1);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      fifo_rsp_type want;
      if (!reset && rsp_valid) begin
         if (predicted_rsp_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected, expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = predicted_rsp_q.pop_front();
            check_field("rd_byte", want.rd_byte, rsp_rd_byte);
            check_field("rd_last", want.rd_last, rsp_rd_last);
            check_field("status", int'(want.status), rsp_status);
            check_field("fill_bytes", want.fill_bytes, rsp_fill_bytes);
            check_field("packet_count", want.packet_count, rsp_packet_count);
         end
      end
   end

   // Empty reads, boundary byte values, a short multi-byte packet, ignored fields on reads
   task automatic test_directed_basics();
      send_item(REQ_READ, 8'hFF, 1'b1);
      send_item(REQ_READ, 8'h00, 1'b0);
      send_item(REQ_WRITE, 8'h00, 1'b1);
      send_item(REQ_WRITE, 8'hFF, 1'b1);
      send_item(REQ_WRITE, 8'hA5, 1'b0);
      send_item(REQ_READ, 8'h3C, 1'b1);   // read while a packet is still open
      send_item(REQ_WRITE, 8'h5A, 1'b0);
      send_item(REQ_WRITE, 8'h81, 1'b1);
      send_reads(5);
      send_item(REQ_READ, 8'hFF, 1'b1);
   endtask

   // End ring full: packets past the slot count are dropped whatever their size
   task automatic test_packet_slot_limit();
      for (int i = 0; i < PKT_DEPTH; i++) send_packet(1, 8'(i));
      send_packet(1, 8'hEE);
      send_packet(2, 8'hD0);
      send_reads(1);
      send_packet(3, 8'h70);
      drain_fifo();
   endtask

   // Byte ring full: overflow, rollback and space freed by reads mid-packet
   task automatic test_byte_capacity();
      send_packet(DATA_DEPTH, 8'h11);
      send_packet(3, 8'hC0);
      send_reads(100);
      for (int i = 0; i < 60; i++) send_item(REQ_WRITE, 8'(i * 3), 1'b0);
      send_reads(20);
      send_packet(60, 8'h40);
      send_packet(1, 8'h99);
      send_reads(10);
      send_packet(11, 8'h20);
      send_packet(10, 8'h60);
      drain_fifo();
   endtask

   function automatic int pick_packet_len();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 95) return $urandom_range(9, 64);
      return $urandom_range(65, 600);
   endfunction

   task automatic test_random_traffic(int n_items);
      int sent;
      int remaining;
      int write_pct;
      sent = 0;
      remaining = 0;
      write_pct = 60;
      while (sent < n_items) begin
         if (sent % 300 == 0) begin
            write_pct = $urandom_range(35, 85);
            idle_pct = (sent / 300 == 2) ? 0 : 13;   // one long stretch without gaps
         end
         if ($urandom_range(99) < write_pct) begin
            if (remaining == 0) remaining = pick_packet_len();
            send_item(REQ_WRITE, 8'($urandom), remaining == 1);
            remaining--;
         end else begin
            send_reads(1);
         end
         sent++;
      end
      idle_pct = 13;
      while (remaining > 0) begin
         send_item(REQ_WRITE, 8'($urandom), remaining == 1);
         remaining--;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_packet_slot_limit();
      test_byte_capacity();
      test_random_traffic(1900);
      start <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/vlpf_pkg.sv
src/vlpf_ram.sv
src/vlpf_core.sv
src/vlpf_rsp.sv
src/variable_length_packet_fifo.sv
src/vlpf_checker.sv
tb/variable_length_packet_fifo_tb.sv
